// ===== design/periodic_timer_table_assert.svh =====
// Assertion macros shared by the timer table RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef PERIODIC_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// Types, request codes and sizes shared by the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int TIME_BITS   = 32;
  localparam int PERIOD_W    = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;

  typedef logic [2:0] req_code_t;

  localparam req_code_t REQ_CLEAR      = 3'd0;
  localparam req_code_t REQ_ADD        = 3'd1;
  localparam req_code_t REQ_ACTIVATE   = 3'd2;
  localparam req_code_t REQ_RESTART    = 3'd3;
  localparam req_code_t REQ_DEACTIVATE = 3'd4;
  localparam req_code_t REQ_PROCESS    = 3'd5;

  typedef struct packed {
    req_code_t   req_type;
    logic [3:0]  entry_index;
    logic [31:0] period_secs;
    logic        start_active;
    logic        immediate;
    logic [31:0] now_time;
  } ptt_req_t;

  typedef struct packed {
    logic       status;
    logic [3:0] result_index;
    logic       fired;
    logic       last;
  } ptt_rsp_t;

  // One write port into the entry table; each field has its own enable.
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     addr;
    logic                 wr_period;
    logic                 wr_start;
    logic                 wr_active;
    logic [PERIOD_W-1:0]  period;
    logic [TIME_BITS-1:0] start;
    logic                 active;
  } ptt_wr_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]  period;
    logic [TIME_BITS-1:0] start;
    logic                 active;
  } ptt_rd_t;

endpackage

// ===== design/ptt_table.sv =====
// ----------------------------------------------------------------------------
// ptt_table
// Entry storage: interval, start time and active flag for each timer.
// ----------------------------------------------------------------------------
module ptt_table (
  input  logic                            clk,
  input  ptt_pkg::ptt_wr_t                wr,
  input  logic [ptt_pkg::IDX_W-1:0]       rd_addr,
  output ptt_pkg::ptt_rd_t                rd
);
  import ptt_pkg::*;

  logic [PERIOD_W-1:0]  period_mem [MAX_ENTRIES];
  logic [TIME_BITS-1:0] start_mem  [MAX_ENTRIES];
  logic                 active_mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.wr_period) begin
        period_mem[wr.addr] <= wr.period;
      end
      if (wr.wr_start) begin
        start_mem[wr.addr] <= wr.start;
      end
      if (wr.wr_active) begin
        active_mem[wr.addr] <= wr.active;
      end
    end
  end

  assign rd.period = period_mem[rd_addr];
  assign rd.start  = start_mem[rd_addr];
  assign rd.active = active_mem[rd_addr];

endmodule

// ===== design/ptt_cmp.sv =====
// ----------------------------------------------------------------------------
// ptt_cmp
// Expiry check shared by every step of a scan: wrapped elapsed time
// against the entry's interval.
// ----------------------------------------------------------------------------
module ptt_cmp (
  input  logic [ptt_pkg::TIME_BITS-1:0] now_time,
  input  ptt_pkg::ptt_rd_t              entry,
  output logic                          fire
);
  import ptt_pkg::*;

  logic [TIME_BITS-1:0] elapsed;

  // Subtraction wraps at the time width, so a counter rollover still works.
  assign elapsed = now_time - entry.start;
  assign fire    = entry.active && (CMP_W'(elapsed) >= CMP_W'(entry.period));

endmodule

// ===== design/periodic_timer_table.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers with add, activate, restart, deactivate, clear
// and a process scan that reports every expired entry.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat arrives on req (req_valid / req_stall); each response
//   beat leaves on rsp (rsp_valid / rsp_stall) through an output register.
//   Clear, add, activate, restart, deactivate and unknown codes give one
//   beat, visible the cycle after acceptance. A process request walks the
//   entries one per cycle, but for the pause below, through a single
//   subtract-and-compare unit: accept, one check per entry, final
//   hand-over; on an empty table it gives one beat like the other codes. A
//   fired entry is held back until the next one is found, so that the
//   final beat carries last; it leaves when the scan ends.
//   The block takes no new request while a scan runs, or while the output
//   register is full and stalled.
//   A stalled response beat holds; the scan pauses when it must hand over
//   a held beat and the output register cannot take it.
//   Reset empties the table (entry count zero) and drops any pending beat;
//   the entry contents are not cleared.
// ----------------------------------------------------------------------------
module periodic_timer_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ptt_pkg::ptt_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ptt_pkg::ptt_rsp_t rsp
);
  import ptt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [CNT_W-1:0]     entry_count, entry_count_next;
  logic [IDX_W-1:0]     scan_idx, scan_idx_next;
  logic [IDX_W-1:0]     pend_idx, pend_idx_next;
  logic                 have_pend, have_pend_next;
  logic [TIME_BITS-1:0] now_reg, now_reg_next;

  ptt_wr_t  wr;
  ptt_rd_t  rd;
  logic     fire;
  logic     out_free;
  logic     load;
  ptt_rsp_t rsp_next;
  logic     accept;
  logic     bad_index;
  logic     scan_end;

  ptt_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (scan_idx),
    .rd      (rd)
  );

  ptt_cmp u_cmp (
    .now_time (now_reg),
    .entry    (rd),
    .fire     (fire)
  );

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == S_IDLE) && out_free);
  assign accept    = req_valid && !req_stall;
  assign bad_index = 32'(req.entry_index) >= 32'(entry_count);
  assign scan_end  = (CNT_W'(scan_idx) + CNT_W'(1)) == entry_count;

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    scan_idx_next    = scan_idx;
    pend_idx_next    = pend_idx;
    have_pend_next   = have_pend;
    now_reg_next     = now_reg;
    wr               = '0;
    load             = 1'b0;
    rsp_next         = '0;
    rsp_next.last    = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (req.req_type)
            REQ_CLEAR: begin
              entry_count_next = '0;
            end
            REQ_ADD: begin
              if (32'(entry_count) >= MAX_ENTRIES) begin
                rsp_next.status = 1'b1;
              end else begin
                entry_count_next      = entry_count + CNT_W'(1);
                rsp_next.result_index = 4'(entry_count);
                wr.en        = 1'b1;
                wr.addr      = IDX_W'(entry_count);
                wr.wr_period = 1'b1;
                wr.period    = PERIOD_W'(req.period_secs);
                wr.wr_active = 1'b1;
                wr.active    = req.start_active;
                wr.wr_start  = req.start_active;
                wr.start     = req.immediate ? '0 : TIME_BITS'(req.now_time);
              end
            end
            REQ_ACTIVATE, REQ_RESTART, REQ_DEACTIVATE: begin
              if (bad_index) begin
                rsp_next.status = 1'b1;
              end else begin
                wr.en   = 1'b1;
                wr.addr = IDX_W'(req.entry_index);
                case (req.req_type)
                  REQ_ACTIVATE: begin
                    wr.wr_start  = 1'b1;
                    wr.start     = req.immediate ? '0 : TIME_BITS'(req.now_time);
                    wr.wr_active = 1'b1;
                    wr.active    = 1'b1;
                  end
                  REQ_RESTART: begin
                    wr.wr_start = 1'b1;
                    wr.start    = TIME_BITS'(req.now_time);
                  end
                  default: begin
                    wr.wr_active = 1'b1;
                    wr.active    = 1'b0;
                  end
                endcase
              end
            end
            REQ_PROCESS: begin
              now_reg_next = TIME_BITS'(req.now_time);
              if (entry_count != '0) begin
                // The response comes from the scan instead.
                load           = 1'b0;
                state_next     = S_SCAN;
                scan_idx_next  = '0;
                have_pend_next = 1'b0;
              end
            end
            default: begin
              rsp_next.status = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // A new hit pushes out the held one, which then cannot be the last.
        if (!(fire && have_pend) || out_free) begin
          if (fire) begin
            if (have_pend) begin
              load                  = 1'b1;
              rsp_next.result_index = 4'(pend_idx);
              rsp_next.fired        = 1'b1;
              rsp_next.last         = 1'b0;
            end
            wr.en          = 1'b1;
            wr.addr        = scan_idx;
            wr.wr_start    = 1'b1;
            wr.start       = now_reg;
            pend_idx_next  = scan_idx;
            have_pend_next = 1'b1;
          end
          if (scan_end) begin
            state_next = S_DONE;
          end else begin
            scan_idx_next = scan_idx + IDX_W'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          load           = 1'b1;
          state_next     = S_IDLE;
          have_pend_next = 1'b0;
          if (have_pend) begin
            rsp_next.result_index = 4'(pend_idx);
            rsp_next.fired        = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      have_pend   <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      have_pend   <= have_pend_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    pend_idx <= pend_idx_next;
    now_reg  <= now_reg_next;
    if (load) begin
      rsp <= rsp_next;
    end
  end

`include "periodic_timer_table_assert.svh"

  `PTT_ASSERT_SAME(a_load_free, load, out_free, "response loaded over a stalled beat")
  `PTT_ASSERT_SAME(a_count_max, 1'b1, 32'(entry_count) <= MAX_ENTRIES, "entry count overflow")
  `PTT_ASSERT_SAME(a_last_fired, rsp_valid && !rsp.last, rsp.fired, "non-final beat not a fire")
  `PTT_ASSERT_NEXT(a_scan_busy, (state == S_SCAN), req_stall || (state == S_IDLE), "accept during scan")

endmodule

// ===== test/periodic_timer_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_table_test
// Self-checking bench for the periodic timer table. A scoreboard predicts
// every response beat from the request stream, and tasks drive requests
// under several idle and stall patterns.
// ----------------------------------------------------------------------------
module periodic_timer_table_test;
  import ptt_pkg::*;

  localparam req_code_t REQ_UNUSED_6 = 3'd6;
  localparam req_code_t REQ_UNUSED_7 = 3'd7;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam int PHASE_ITEMS    = 110;
  localparam int HOLD_ITEMS     = 20;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 50;
  localparam int WATCHDOG_LIMIT = 2000;

  class timer_table_scoreboard;
    ptt_rsp_t    due_rsp_q[$];
    int unsigned mismatches;
    int unsigned entry_count;
    logic [31:0] period_tbl[MAX_ENTRIES];
    logic [31:0] start_tbl[MAX_ENTRIES];
    bit          active_tbl[MAX_ENTRIES];

    function new();
      mismatches  = 0;
      entry_count = 0;
      foreach (period_tbl[i]) begin
        period_tbl[i] = '0;
        start_tbl[i]  = '0;
        active_tbl[i] = 1'b0;
      end
    endfunction

    function ptt_rsp_t beat(logic st, logic [3:0] idx, logic fr, logic lst);
      ptt_rsp_t b;
      b.status       = st;
      b.result_index = idx;
      b.fired        = fr;
      b.last         = lst;
      return b;
    endfunction

    function int pending();
      return due_rsp_q.size();
    endfunction

    // Updates the table copy and queues the response beats one request causes.
    function void note_request(ptt_req_t r);
      logic [3:0]  fired_q[$];
      logic [31:0] elapsed;
      int unsigned slot;
      case (r.req_type)
        REQ_CLEAR: begin
          entry_count = 0;
          due_rsp_q.push_back(beat(STATUS_OK, 4'd0, 1'b0, 1'b1));
        end
        REQ_ADD: begin
          if (entry_count >= MAX_ENTRIES) begin
            due_rsp_q.push_back(beat(STATUS_ERR, 4'd0, 1'b0, 1'b1));
          end else begin
            slot = entry_count;
            entry_count++;
            period_tbl[slot] = r.period_secs;
            if (r.start_active) begin
              start_tbl[slot]  = r.immediate ? 32'd0 : r.now_time;
              active_tbl[slot] = 1'b1;
            end else begin
              active_tbl[slot] = 1'b0;
            end
            due_rsp_q.push_back(beat(STATUS_OK, 4'(slot), 1'b0, 1'b1));
          end
        end
        REQ_ACTIVATE, REQ_RESTART, REQ_DEACTIVATE: begin
          if (r.entry_index >= entry_count) begin
            due_rsp_q.push_back(beat(STATUS_ERR, 4'd0, 1'b0, 1'b1));
          end else begin
            if (r.req_type == REQ_ACTIVATE) begin
              start_tbl[r.entry_index]  = r.immediate ? 32'd0 : r.now_time;
              active_tbl[r.entry_index] = 1'b1;
            end else if (r.req_type == REQ_RESTART) begin
              start_tbl[r.entry_index] = r.now_time;
            end else begin
              active_tbl[r.entry_index] = 1'b0;
            end
            due_rsp_q.push_back(beat(STATUS_OK, 4'd0, 1'b0, 1'b1));
          end
        end
        REQ_PROCESS: begin
          for (int i = 0; i < entry_count; i++) begin
            elapsed = r.now_time - start_tbl[i];
            if (active_tbl[i] && elapsed >= period_tbl[i]) begin
              start_tbl[i] = r.now_time;
              fired_q.push_back(4'(i));
            end
          end
          if (fired_q.size() == 0) begin
            due_rsp_q.push_back(beat(STATUS_OK, 4'd0, 1'b0, 1'b1));
          end else begin
            foreach (fired_q[k]) begin
              due_rsp_q.push_back(beat(STATUS_OK, fired_q[k], 1'b1,
                                       k == fired_q.size() - 1));
            end
          end
        end
        default: begin
          due_rsp_q.push_back(beat(STATUS_ERR, 4'd0, 1'b0, 1'b1));
        end
      endcase
    endfunction

    function void check_result(ptt_rsp_t got);
      ptt_rsp_t want;
      if (due_rsp_q.size() == 0) begin
        $error("response beat with nothing due: %p", got);
        mismatches++;
        return;
      end
      want = due_rsp_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.result_index !== want.result_index) begin
        $error("result_index: expected %0d, got %0d", want.result_index,
               got.result_index);
        mismatches++;
      end
      if (got.fired !== want.fired) begin
        $error("fired: expected %0d, got %0d", want.fired, got.fired);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  ptt_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  ptt_rsp_t rsp;

  timer_table_scoreboard sb;
  int          idle_pct;
  int          stall_pct;
  bit          long_hold;
  logic [31:0] now_t;
  int          stuck_cycles;

  periodic_timer_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or one long hold-off on request.
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Both channels are sampled here, before any update of this edge lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
      if (req_valid && !req_stall) sb.note_request(req);
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  function automatic ptt_req_t make_req(req_code_t code, logic [3:0] idx,
                                        logic [31:0] period, logic act,
                                        logic imm, logic [31:0] now);
    ptt_req_t r;
    r.req_type     = code;
    r.entry_index  = idx;
    r.period_secs  = period;
    r.start_active = act;
    r.immediate    = imm;
    r.now_time     = now;
    return r;
  endfunction

  // Time mostly moves forward in small steps so that entries keep expiring;
  // an occasional jump lands anywhere, including across the wrap.
  function automatic ptt_req_t rand_req();
    ptt_req_t r;
    int       pick;
    int       cnt;
    cnt  = sb.entry_count;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) now_t = $urandom;
    else now_t += $urandom_range(0, 6);
    r.now_time     = now_t;
    r.start_active = ($urandom_range(0, 99) < 75);
    r.immediate    = ($urandom_range(0, 99) < 30);
    case ($urandom_range(0, 19))
      0, 1:    r.period_secs = $urandom;
      2, 3, 4: r.period_secs = $urandom_range(0, 200);
      default: r.period_secs = $urandom_range(0, 12);
    endcase
    if ($urandom_range(0, 99) < 80) r.entry_index = 4'($urandom_range(0, cnt > 0 ? cnt - 1 : 0));
    else r.entry_index = 4'($urandom_range(0, 15));
    if (pick < 35)      r.req_type = REQ_PROCESS;
    else if (pick < 50) r.req_type = REQ_ADD;
    else if (pick < 63) r.req_type = REQ_ACTIVATE;
    else if (pick < 73) r.req_type = REQ_RESTART;
    else if (pick < 83) r.req_type = REQ_DEACTIVATE;
    else if (pick < 86) r.req_type = REQ_CLEAR;
    else if (pick < 88) r.req_type = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
    else                r.req_type = REQ_PROCESS;
    return r;
  endfunction

  task automatic send_req(ptt_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    // Let the monitor note the beat accepted at this edge first.
    #1;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    rst          <= 1'b1;
    req_valid    <= 1'b0;
    req          <= '0;
    stuck_cycles <= 0;
    idle_pct     = 0;
    stall_pct    = 0;
    long_hold    = 1'b0;
    now_t        = '0;
    phase_idle   = '{0, 61, 0, 6};
    phase_stall  = '{0, 0, 61, 6};
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_req(make_req(REQ_PROCESS, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0));
    send_req(make_req(REQ_DEACTIVATE, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0));
    send_req(make_req(REQ_ADD, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_req(make_req(REQ_ADD, 4'd9, 32'd5, 1'b0, 1'b1, 32'd20));
    // Entry 0 started at zero, so a full-scale elapsed time meets its period.
    send_req(make_req(REQ_PROCESS, 4'd0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_req(make_req(REQ_ACTIVATE, 4'd1, 32'd0, 1'b0, 1'b1, 32'd3));
    send_req(make_req(REQ_RESTART, 4'd0, 32'd0, 1'b1, 1'b0, 32'd10));
    send_req(make_req(REQ_PROCESS, 4'd0, 32'd0, 1'b0, 1'b0, 32'd5));
    send_req(make_req(REQ_ACTIVATE, 4'd15, 32'd0, 1'b1, 1'b0, 32'd6));
    send_req(make_req(REQ_RESTART, 4'd2, 32'd0, 1'b0, 1'b0, 32'd6));
    send_req(make_req(REQ_UNUSED_6, 4'd0, 32'd0, 1'b0, 1'b0, 32'd6));
    send_req(make_req(REQ_UNUSED_7, 4'd0, 32'd0, 1'b0, 1'b0, 32'd6));
    send_req(make_req(REQ_CLEAR, 4'd0, 32'd0, 1'b0, 1'b0, 32'd7));
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      send_req(make_req(REQ_ADD, 4'(i), 32'd0, 1'b1, 1'b0, 32'd7));
    end
    send_req(make_req(REQ_ADD, 4'd0, 32'd1, 1'b1, 1'b0, 32'd7));
    // Every entry has a zero period, so one scan fires all of them.
    send_req(make_req(REQ_PROCESS, 4'd0, 32'd0, 1'b0, 1'b0, 32'd7));
    now_t = 32'd7;
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (PHASE_ITEMS) send_req(rand_req());
      wait_drained();
      if (p == 0) begin
        // Long receiver hold-off while requests keep coming, so the block
        // backs up and stalls its input.
        long_hold = 1'b1;
        repeat (HOLD_ITEMS) send_req(rand_req());
        wait_drained();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/ptt_pkg.sv
design/ptt_table.sv
design/ptt_cmp.sv
design/periodic_timer_table.sv
test/periodic_timer_table_test.sv
